/* sv/double_ended_queue_macros.svh */
// assertion macros shared by the double-ended queue modules
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define DEQ_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DEQ_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/deq_pkg.sv */
// shared types and codes for the double-ended queue
`default_nettype none

package deq_pkg;

    // fixed field widths
    localparam int ACTION_W = 3;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 10;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_READ       = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_WRITE      = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STS_RANGE = 2'd3;

    // controller to datapath
    typedef struct packed {
        logic accept;      // transaction taken on the request side this cycle
        logic load_rdata;  // capture memory read data into the result
    } deq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic read_hit;    // current request is a read inside the queue
    } deq_sts_t;

endpackage

`default_nettype wire

/* sv/deq_in_if.sv */
// request channel: action, element value and logical index
`default_nettype none

interface deq_in_if;
    logic                         valid;
    logic                         ready;
    logic [deq_pkg::ACTION_W-1:0] action;
    logic [deq_pkg::DATA_W-1:0]   data_in;
    logic [deq_pkg::POS_W-1:0]    position;

    modport source (output valid, output action, output data_in, output position,
                    input ready);
    modport sink   (input valid, input action, input data_in, input position,
                    output ready);
endinterface

`default_nettype wire

/* sv/deq_out_if.sv */
// response channel: read value, status code and element count
`default_nettype none

interface deq_out_if;
    logic                         valid;
    logic                         ready;
    logic [deq_pkg::DATA_W-1:0]   read_data;
    logic [deq_pkg::STATUS_W-1:0] status;
    logic [deq_pkg::COUNT_W-1:0]  count;

    modport source (output valid, output read_data, output status, output count,
                    input ready);
    modport sink   (input valid, input read_data, input status, input count,
                    output ready);
endinterface

`default_nettype wire

/* sv/deq_ram.sv */
// generic single-port ram with registered read
`default_nettype none

module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [WIDTH-1:0] wdata,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one access per cycle, read data registered and shown in the next cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

/* sv/deq_ctrl.sv */
// handshake and sequencing state machine for the double-ended queue
`default_nettype none
`include "double_ended_queue_macros.svh"

module deq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    input  wire deq_pkg::deq_sts_t sts,
    output deq_pkg::deq_cmd_t      cmd
);

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_READ = 1'b1;

    logic [0:0] state_reg;
    logic [0:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       accept;

    // take a request when idle and the result register is free by the next edge
    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;

    assign cmd.accept     = accept;
    assign cmd.load_rdata = (state_reg == ST_READ);

    // next state: a read inside the queue waits in ST_READ for memory data
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && sts.read_hit)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if ((accept && !sts.read_hit) || (state_reg == ST_READ))
        begin
            rsp_valid_next = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    `DEQ_ASSERT_IMP(a_read_slot_free, state_reg == ST_READ, !rsp_valid_reg, "result busy during read")
    `DEQ_ASSERT_NXT(a_read_enters_wait, accept && sts.read_hit, state_reg == ST_READ, "read wait missed")
    `DEQ_ASSERT_NXT(a_read_gives_result, state_reg == ST_READ, rsp_valid_reg, "read result not shown")

endmodule

`default_nettype wire

/* sv/deq_dp.sv */
// pointers, fill count, ring storage and result register of the queue
`default_nettype none
`include "double_ended_queue_macros.svh"

module deq_dp #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire deq_pkg::deq_cmd_t            cmd,
    output deq_pkg::deq_sts_t                 sts,
    input  wire logic [deq_pkg::ACTION_W-1:0] action,
    input  wire logic [deq_pkg::DATA_W-1:0]   data_in,
    input  wire logic [deq_pkg::POS_W-1:0]    position,
    output logic      [deq_pkg::DATA_W-1:0]   read_data,
    output logic      [deq_pkg::STATUS_W-1:0] status,
    output logic      [deq_pkg::COUNT_W-1:0]  count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = ((AW > deq_pkg::POS_W) ? AW : deq_pkg::POS_W) + 1;
    localparam int KW = (CW > deq_pkg::POS_W) ? CW : deq_pkg::POS_W;
    localparam int XW = (CW > deq_pkg::COUNT_W) ? CW : deq_pkg::COUNT_W;

    logic [AW-1:0]                  head_reg;
    logic [AW-1:0]                  head_next;
    logic [CW-1:0]                  fill_reg;
    logic [CW-1:0]                  fill_next;
    logic [deq_pkg::DATA_W-1:0]     read_data_reg;
    logic [deq_pkg::STATUS_W-1:0]   status_reg;
    logic [deq_pkg::STATUS_W-1:0]   status_next;
    logic [deq_pkg::COUNT_W-1:0]    count_reg;
    logic [XW-1:0]                  fill_x;
    logic                           is_full;
    logic                           is_empty;
    logic                           in_range;
    logic [SW-1:0]                  idx;
    logic [SW-1:0]                  sum;
    logic [SW-1:0]                  wrapped;
    logic [AW-1:0]                  slot;
    logic [AW-1:0]                  head_dec;
    logic [AW-1:0]                  head_inc;
    logic                           ram_we;
    logic [AW-1:0]                  ram_addr;
    logic [DATA_WIDTH-1:0]          ram_wdata;
    logic [DATA_WIDTH-1:0]          ram_rdata;
    logic                           push_ok;

    // occupancy and range checks
    assign is_full  = (fill_reg == CW'(DEPTH));
    assign is_empty = (fill_reg == '0);
    assign in_range = (KW'(position) < KW'(fill_reg));

    // logical index to slot: back end uses fill, read and write use position
    assign idx     = (action == deq_pkg::ACT_PUSH_BACK) ? SW'(fill_reg) : SW'(position);
    assign sum     = SW'(head_reg) + idx;
    assign wrapped = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;
    assign slot    = wrapped[AW-1:0];

    // head moves around the ring
    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : (head_reg - 1'b1);
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : (head_reg + 1'b1);

    assign ram_wdata    = DATA_WIDTH'(data_in);
    assign sts.read_hit = (action == deq_pkg::ACT_READ) && in_range;

    // action decode: state update, memory access and status
    always_comb
    begin
        head_next   = head_reg;
        fill_next   = fill_reg;
        status_next = deq_pkg::STS_OK;
        ram_we      = 1'b0;
        ram_addr    = slot;
        case (action)
            deq_pkg::ACT_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status_next = deq_pkg::STS_FULL;
                end
                else
                begin
                    ram_we    = cmd.accept;
                    fill_next = fill_reg + 1'b1;
                end
            end
            deq_pkg::ACT_PUSH_FRONT:
            begin
                ram_addr = head_dec;
                if (is_full)
                begin
                    status_next = deq_pkg::STS_FULL;
                end
                else
                begin
                    ram_we    = cmd.accept;
                    head_next = head_dec;
                    fill_next = fill_reg + 1'b1;
                end
            end
            deq_pkg::ACT_POP_BACK:
            begin
                if (is_empty)
                begin
                    status_next = deq_pkg::STS_EMPTY;
                end
                else
                begin
                    fill_next = fill_reg - 1'b1;
                end
            end
            deq_pkg::ACT_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status_next = deq_pkg::STS_EMPTY;
                end
                else
                begin
                    head_next = head_inc;
                    fill_next = fill_reg - 1'b1;
                end
            end
            deq_pkg::ACT_READ:
            begin
                if (!in_range)
                begin
                    status_next = deq_pkg::STS_RANGE;
                end
            end
            deq_pkg::ACT_WRITE:
            begin
                if (!in_range)
                begin
                    status_next = deq_pkg::STS_RANGE;
                end
                else
                begin
                    ram_we = cmd.accept;
                end
            end
            default:
            begin
                status_next = deq_pkg::STS_OK;
            end
        endcase
    end

    // count field is the fill after the action, cut to the port width
    assign fill_x = XW'(fill_next);

    // ring storage
    deq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else if (cmd.accept)
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            read_data_reg <= '0;
            status_reg    <= status_next;
            count_reg     <= fill_x[deq_pkg::COUNT_W-1:0];
        end
        else if (cmd.load_rdata)
        begin
            read_data_reg <= deq_pkg::DATA_W'(ram_rdata);
        end
    end

    assign read_data = read_data_reg;
    assign status    = status_reg;
    assign count     = count_reg;

    // accepted push with room left
    assign push_ok = cmd.accept && !is_full &&
                     ((action == deq_pkg::ACT_PUSH_BACK) || (action == deq_pkg::ACT_PUSH_FRONT));

    `DEQ_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= CW'(DEPTH), "fill above capacity")
    `DEQ_ASSERT_NXT(a_push_grows, push_ok, fill_reg == $past(fill_reg) + 1'b1, "fill not grown")

endmodule

`default_nettype wire

/* sv/double_ended_queue.sv */
// Double-ended queue on a ring of DEPTH slots, one action per request transaction.
// Result: registered on acceptance; a read inside the queue waits in ST_READ for ram data.
// Throughput: one transaction per cycle with no response stall; a read inside the queue
// holds the request side while the single-port ram delivers its registered read data.
// Reset (async, active low) clears head, fill and handshake state; slot contents stay
// undefined with no clearing pass, so requests are taken from the first cycle.
`default_nettype none

module double_ended_queue #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    deq_in_if.sink     req,
    deq_out_if.source  rsp
);

    deq_pkg::deq_cmd_t cmd;
    deq_pkg::deq_sts_t sts;

    // handshake and sequencing
    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // pointers, storage and result
    deq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .action    (req.action),
        .data_in   (req.data_in),
        .position  (req.position),
        .read_data (rsp.read_data),
        .status    (rsp.status),
        .count     (rsp.count)
    );

endmodule

`default_nettype wire

/* sim/deq_checker.sv */
// scoreboard for the double-ended queue: predicts each response and compares it
module deq_checker (
    input  logic clk,
    input  logic rst_n,
    deq_in_if    mon_req,
    deq_out_if   mon_rsp,
    output int   fail_count,
    output int   pending_count,
    output int   checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = 1024;

    typedef struct packed {
        logic [deq_pkg::DATA_W-1:0]   read_data;
        logic [deq_pkg::STATUS_W-1:0] status;
        logic [deq_pkg::COUNT_W-1:0]  count;
    } deq_result_t;

    // shadow copy of the queue
    logic [deq_pkg::DATA_W-1:0]  ring [RING_DEPTH];
    logic [deq_pkg::POS_W-1:0]   front_slot;
    logic [deq_pkg::COUNT_W-1:0] held;

    deq_result_t expected_rsp_q[$];
    int          mismatches = 0;
    int          checked    = 0;

    // apply one action to the shadow queue and return the response it gives
    function automatic deq_result_t apply_action(input logic [deq_pkg::ACTION_W-1:0] act,
                                                 input logic [deq_pkg::DATA_W-1:0]   data,
                                                 input logic [deq_pkg::POS_W-1:0]    pos);
        deq_result_t                r;
        logic [deq_pkg::POS_W-1:0]  slot;
        logic [deq_pkg::POS_W-1:0]  back_slot;
        r         = '0;
        slot      = front_slot + pos;
        back_slot = front_slot + held[deq_pkg::POS_W-1:0];
        case (act)
            deq_pkg::ACT_PUSH_BACK:
                if (held >= RING_DEPTH) r.status = deq_pkg::STS_FULL;
                else
                begin
                    ring[back_slot] = data;
                    held = held + 1'b1;
                end
            deq_pkg::ACT_PUSH_FRONT:
                if (held >= RING_DEPTH) r.status = deq_pkg::STS_FULL;
                else
                begin
                    front_slot       = front_slot - 1'b1;
                    ring[front_slot] = data;
                    held             = held + 1'b1;
                end
            deq_pkg::ACT_POP_BACK:
                if (held == 0) r.status = deq_pkg::STS_EMPTY;
                else held = held - 1'b1;
            deq_pkg::ACT_POP_FRONT:
                if (held == 0) r.status = deq_pkg::STS_EMPTY;
                else
                begin
                    front_slot = front_slot + 1'b1;
                    held       = held - 1'b1;
                end
            deq_pkg::ACT_READ:
                if ({1'b0, pos} >= held) r.status = deq_pkg::STS_RANGE;
                else r.read_data = ring[slot];
            deq_pkg::ACT_WRITE:
                if ({1'b0, pos} >= held) r.status = deq_pkg::STS_RANGE;
                else ring[slot] = data;
            default: ;
        endcase
        r.count = held;
        return r;
    endfunction

    // response side first: a request taken on this edge cannot answer on it
    always @(posedge clk or negedge rst_n)
    begin
        deq_result_t got;
        deq_result_t want;
        deq_result_t predicted;
        if (!rst_n)
        begin
            front_slot = '0;
            held       = '0;
            expected_rsp_q.delete();
        end
        else
        begin
            if (mon_rsp.valid && mon_rsp.ready)
            begin
                got.read_data = mon_rsp.read_data;
                got.status    = mon_rsp.status;
                got.count     = mon_rsp.count;
                if (expected_rsp_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("checker: unexpected response data=%h status=%0d count=%0d",
                                 got.read_data, got.status, got.count);
                end
                else
                begin
                    want = expected_rsp_q[0];
                    expected_rsp_q.delete(0);
                    checked++;
                    if (got.read_data !== want.read_data || got.status !== want.status ||
                        got.count !== want.count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"checker: response %0d mismatch: data exp %h got %h, ",
                                      "status exp %0d got %0d, count exp %0d got %0d"},
                                     checked, want.read_data, got.read_data,
                                     want.status, got.status, want.count, got.count);
                    end
                end
            end
            if (mon_req.valid && mon_req.ready)
            begin
                predicted = apply_action(mon_req.action, mon_req.data_in, mon_req.position);
                expected_rsp_q = {expected_rsp_q, predicted};
            end
        end
        fail_count    <= mismatches;
        pending_count <= expected_rsp_q.size();
        checked_count <= checked;
    end

endmodule

/* sim/tb.sv */
// top-level testbench for the double-ended queue: stimulus, backpressure and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = 1024;

    // action codes the block ignores
    localparam logic [deq_pkg::ACTION_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [deq_pkg::ACTION_W-1:0] ACT_SPARE_B = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    logic quiet = 1'b0;
    int   stall_left = 0;

    // request-side bookkeeping used to steer the stimulus
    int shadow_fill    = 0;
    int peak_fill      = 0;
    int full_refusals  = 0;
    int empty_refusals = 0;
    int sent_count     = 0;

    int chk_fail;
    int chk_pending;
    int chk_checked;

    deq_in_if  req_ch ();
    deq_out_if rsp_ch ();

    double_ended_queue #(
        .DEPTH      (RING_DEPTH),
        .DATA_WIDTH (deq_pkg::DATA_W)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    deq_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .mon_req       (req_ch),
        .mon_rsp       (rsp_ch),
        .fail_count    (chk_fail),
        .pending_count (chk_pending),
        .checked_count (chk_checked)
    );

    // 2 ns clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // response backpressure in random bursts
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 9) == 0)
        begin
            stall_left   <= $urandom_range(0, 9);
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= 1'b1;
    end

    // present one request and hold it until the transaction completes
    task automatic send_req(input logic [deq_pkg::ACTION_W-1:0] act,
                            input logic [deq_pkg::DATA_W-1:0]   data,
                            input logic [deq_pkg::POS_W-1:0]    pos);
        int   gap;
        logic accepted;
        if (!quiet && $urandom_range(0, 11) == 0)
        begin
            req_ch.valid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.action   <= act;
        req_ch.data_in  <= data;
        req_ch.position <= pos;
        accepted = 1'b0;
        while (!accepted)
        begin
            @(negedge clk);
            accepted = req_ch.ready;
            @(posedge clk);
        end
        sent_count++;
        if (act == deq_pkg::ACT_PUSH_BACK || act == deq_pkg::ACT_PUSH_FRONT)
        begin
            if (shadow_fill < RING_DEPTH) shadow_fill++;
            else full_refusals++;
        end
        else if (act == deq_pkg::ACT_POP_BACK || act == deq_pkg::ACT_POP_FRONT)
        begin
            if (shadow_fill > 0) shadow_fill--;
            else empty_refusals++;
        end
        if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    endtask

    // one random request, weighted toward pushes or pops by the caller
    task automatic send_random(input int push_pct, input int pop_pct);
        int                           r;
        int                           sel;
        int                           pick;
        logic [deq_pkg::ACTION_W-1:0] act;
        logic [deq_pkg::DATA_W-1:0]   data;
        logic [deq_pkg::POS_W-1:0]    pos;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            act = $urandom_range(0, 1) ? deq_pkg::ACT_PUSH_FRONT : deq_pkg::ACT_PUSH_BACK;
        else if (r < push_pct + pop_pct)
            act = $urandom_range(0, 1) ? deq_pkg::ACT_POP_FRONT : deq_pkg::ACT_POP_BACK;
        else if (r < 98)
            act = $urandom_range(0, 1) ? deq_pkg::ACT_WRITE : deq_pkg::ACT_READ;
        else
            act = $urandom_range(0, 1) ? ACT_SPARE_B : ACT_SPARE_A;
        sel = $urandom_range(0, 9);
        if (sel == 0) data = '0;
        else if (sel == 1) data = '1;
        else data = $urandom();
        // mostly inside the queue, some just past the back, some anywhere
        sel = $urandom_range(0, 9);
        if (sel < 7 && shadow_fill > 0)
            pick = $urandom_range(0, shadow_fill - 1);
        else if (sel < 9)
            pick = (shadow_fill >= RING_DEPTH) ? RING_DEPTH - 1 : shadow_fill;
        else
            pick = $urandom();
        pos = pick[deq_pkg::POS_W-1:0];
        send_req(act, data, pos);
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.action   <= deq_pkg::ACT_PUSH_BACK;
        req_ch.data_in  <= '0;
        req_ch.position <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue: refused pops, out-of-range access, ignored codes
        send_req(deq_pkg::ACT_POP_BACK,   32'h0000_0000, 10'd0);
        send_req(deq_pkg::ACT_POP_FRONT,  32'hFFFF_FFFF, 10'd0);
        send_req(deq_pkg::ACT_READ,       32'h0000_0000, 10'd0);
        send_req(deq_pkg::ACT_WRITE,      32'hFFFF_FFFF, 10'd1023);
        send_req(ACT_SPARE_A,             32'hFFFF_FFFF, 10'd1023);
        send_req(ACT_SPARE_B,             32'h0000_0000, 10'd0);
        // fill both ends and read back
        send_req(deq_pkg::ACT_PUSH_BACK,  32'hFFFF_FFFF, 10'd0);
        send_req(deq_pkg::ACT_PUSH_FRONT, 32'h0000_0000, 10'd1023);
        send_req(deq_pkg::ACT_PUSH_BACK,  32'hA5A5_A5A5, 10'd0);
        send_req(deq_pkg::ACT_READ,       32'h0000_0000, 10'd0);
        send_req(deq_pkg::ACT_READ,       32'h0000_0000, 10'd1);
        send_req(deq_pkg::ACT_READ,       32'h0000_0000, 10'd2);
        send_req(deq_pkg::ACT_READ,       32'h0000_0000, 10'd3);
        send_req(deq_pkg::ACT_WRITE,      32'h5A5A_5A5A, 10'd1);
        send_req(deq_pkg::ACT_READ,       32'h0000_0000, 10'd1);
        send_req(deq_pkg::ACT_WRITE,      32'h1234_5678, 10'd3);
        // drain to empty, then one refused pop and a front push into slot zero
        send_req(deq_pkg::ACT_POP_BACK,   32'h0000_0000, 10'd0);
        send_req(deq_pkg::ACT_POP_FRONT,  32'h0000_0000, 10'd0);
        send_req(deq_pkg::ACT_READ,       32'h0000_0000, 10'd0);
        send_req(deq_pkg::ACT_POP_FRONT,  32'h0000_0000, 10'd0);
        send_req(deq_pkg::ACT_POP_BACK,   32'h0000_0000, 10'd0);
        send_req(deq_pkg::ACT_PUSH_FRONT, 32'h8765_4321, 10'd0);
        send_req(deq_pkg::ACT_READ,       32'h0000_0000, 10'd0);

        // balanced mix around the low end
        repeat (250) send_random(40, 30);
        // push hard until full, then work at capacity
        while (shadow_fill < RING_DEPTH) send_random(90, 4);
        repeat (60) send_random(50, 10);
        // last stretch with no idling on either side
        quiet <= 1'b1;
        repeat (200) send_random(20, 60);
        req_ch.valid <= 1'b0;

        // let the last transaction reach the scoreboard before waiting on it
        @(posedge clk);
        while (chk_pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);

        $display("tb: %0d requests sent, %0d responses checked, fill peaked at %0d of %0d",
                 sent_count, chk_checked, peak_fill, RING_DEPTH);
        $display("tb: %0d pushes refused when full, %0d pops refused when empty",
                 full_refusals, empty_refusals);
        if (chk_fail == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #400000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
